// File: hw/rtl/proportional_glyph_text_renderer_core_defines.svh
// assertion macros shared by the glyph renderer rtl
`ifndef PROPORTIONAL_GLYPH_TEXT_RENDERER_CORE_DEFINES_SVH
`define PROPORTIONAL_GLYPH_TEXT_RENDERER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define PGTR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define PGTR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pgtr_pkg.sv
// types, constants and helper functions of the glyph text renderer
package pgtr_pkg;

	localparam int GLYPH_COUNT_DEF = 38;
	localparam int GLYPH_ROWS      = 16;
	localparam int ROW_W           = 4;
	localparam int GLYPH_IDX_W     = 6;
	localparam int CHAR_W          = 8;
	localparam int PIX_W           = 16;
	localparam int CUR_W           = 16;
	localparam int ADDR_W          = 25;
	localparam int SPAN_W          = 5;
	localparam int STRIDE_W        = 9;
	localparam int ADV_W           = 8;
	localparam int CFG_DATA_W      = 16;
	localparam int CFG_IDX_W       = 2;

	localparam logic [STRIDE_W-1:0] STRIDE_RST    = 9'd400;
	localparam logic [ADV_W-1:0]    LINE_ADV_RST  = 8'd20;
	localparam logic [CUR_W-1:0]    START_ROW_RST = 16'd480;
	localparam logic [CUR_W-1:0]    UNMAPPED_ADV  = 16'd14;
	localparam logic [CUR_W-1:0]    GLYPH_GAP     = 16'd2;
	localparam logic [CHAR_W-1:0]   CHAR_NEWLINE  = 8'h0a;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_ADVANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW    = 2'd2;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [CHAR_W-1:0]      char_code;
		logic [GLYPH_IDX_W-1:0] glyph_index;
		logic [ROW_W-1:0]       glyph_row;
		logic [PIX_W-1:0]       row_pattern;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] row_address;
		logic [PIX_W-1:0]  row_bits;
		logic [SPAN_W-1:0] span;
		logic              last_row;
	} out_item_t;

	typedef struct packed {
		logic                   hit;
		logic [GLYPH_IDX_W-1:0] idx;
	} glyph_map_t;

	// character to glyph slot: '-', '.', digits, then letters of either case
	function automatic glyph_map_t glyph_of(input logic [CHAR_W-1:0] c);
		glyph_map_t m;
		m.hit = 1'b1;
		m.idx = '0;
		if (c == 8'h2d) begin
			m.idx = 6'd0;
		end else if (c == 8'h2e) begin
			m.idx = 6'd1;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			m.idx = GLYPH_IDX_W'(c - 8'h30 + 8'd2);
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			m.idx = GLYPH_IDX_W'(c - 8'h41 + 8'd12);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			m.idx = GLYPH_IDX_W'(c - 8'h61 + 8'd12);
		end else begin
			m.hit = 1'b0;
		end
		return m;
	endfunction

	// pixels up to the lowest set bit, one for an empty row
	function automatic logic [SPAN_W-1:0] span_of(input logic [PIX_W-1:0] bits);
		logic [SPAN_W-1:0] sp;
		sp = 5'd1;
		for (int i = PIX_W - 1; i >= 0; i--) begin
			if (bits[i]) begin
				sp = SPAN_W'(PIX_W - i);
			end
		end
		return sp;
	endfunction

endpackage

// File: hw/rtl/pgtr_if.sv
// valid/ready channel interfaces for input and result requests
interface pgtr_in_if import pgtr_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pgtr_out_if import pgtr_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pgtr_ram.sv
// generic single-port-write, registered-read synchronous ram
module pgtr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 608
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/proportional_glyph_text_renderer_core.sv
// top level of the proportional 16x16 glyph text renderer
// Usage:
// in_ch takes requests: a load (action 0) writes one 16-bit row into glyph
// slot glyph_index, row glyph_row; a draw (action 1) renders char_code at the
// text cursor. out_ch gives one request per glyph row: byte address, row bits,
// span and a last_row flag on the sixteenth row.
// A drawn glyph issues one glyph memory read per cycle while out_ch does not
// stall, so its 16 rows leave at one per cycle while out_ch takes them; the
// first row passes the read sequencer, the memory read stage and the output
// register, and the next request is taken once the last row sits in the
// output register. Newlines and characters without a glyph give no rows.
// cfg_we/cfg_index/cfg_data write row_stride (0), line_advance (1) and
// start_row (2); start_row is copied into cursor y at once. Write only idle.
// Reset clears the cursor x, sets y to 480 and restores the register
// defaults; glyph rows hold no value until loaded.
// A stalled out_ch holds its request; the read sequencer waits behind it.
`include "proportional_glyph_text_renderer_core_defines.svh"

module proportional_glyph_text_renderer_core import pgtr_pkg::*; #(
	parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pgtr_in_if.sink               in_ch,
	pgtr_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [GLYPH_IDX_W:0] GLYPH_LIMIT = (GLYPH_IDX_W + 1)'(GLYPH_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                 state_q;
	logic [STRIDE_W-1:0]    row_stride_q;
	logic [ADV_W-1:0]       line_advance_q;
	logic [CUR_W-1:0]       cursor_x_q;
	logic [CUR_W-1:0]       cursor_y_q;
	logic [GLYPH_IDX_W-1:0] glyph_q;
	logic [ROW_W-1:0]       row_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [ROW_W-1:0]       widest_q;

	logic                   valid_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [ADDR_W-1:0]      addr_s1;

	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic                   in_acc;
	in_item_t               item;
	glyph_map_t             map;
	logic                   draw_hit;
	logic                   load_ok;
	logic                   rd_go;
	logic                   move_s1;
	logic [ADDR_W-1:0]      base_addr;
	logic [PIX_W-1:0]       rd_bits;
	logic [SPAN_W-1:0]      rd_span;
	logic [ROW_W-1:0]       rd_width;
	logic [ROW_W-1:0]       widest_nxt;
	logic [AW-1:0]          ram_waddr;
	logic [AW-1:0]          ram_raddr;

	// handshake and decode
	assign in_ch.ready = (state_q == ST_IDLE) && !valid_s1;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign item        = in_ch.data;
	assign map         = glyph_of(item.char_code);
	assign draw_hit    = map.hit && ({1'b0, map.idx} < GLYPH_LIMIT);
	assign load_ok     = in_acc && (item.action == ACT_LOAD)
		&& ({1'b0, item.glyph_index} < GLYPH_LIMIT);

	// base address of the glyph's top row
	assign base_addr = ADDR_W'(cursor_y_q) * ADDR_W'(row_stride_q) + ADDR_W'(cursor_x_q);

	// glyph memory addressing
	assign ram_waddr = AW'({item.glyph_index, item.glyph_row});
	assign ram_raddr = AW'({glyph_q, row_q});

	pgtr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (ram_waddr),
		.wdata (item.row_pattern),
		.re    (rd_go),
		.raddr (ram_raddr),
		.rdata (rd_bits)
	);

	// read issue and stage advance
	assign move_s1 = valid_s1 && (!out_valid_q || out_ch.ready);
	assign rd_go   = (state_q == ST_RUN) && (!valid_s1 || move_s1);

	// span of the row leaving the memory stage and the running widest
	assign rd_span    = span_of(rd_bits);
	assign rd_width   = ROW_W'(rd_span - 5'd1);
	assign widest_nxt = (row_s1 == '0 || rd_width > widest_q) ? rd_width : widest_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q   <= STRIDE_RST;
			line_advance_q <= LINE_ADV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_STRIDE:   row_stride_q   <= cfg_data[STRIDE_W-1:0];
				REG_LINE_ADVANCE: line_advance_q <= cfg_data[ADV_W-1:0];
				default: ;
			endcase
		end
	end

	// text cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= START_ROW_RST;
		end else begin
			priority if (cfg_we && cfg_index == REG_START_ROW) begin
				cursor_y_q <= cfg_data[CUR_W-1:0];
			end else if (in_acc && item.action == ACT_DRAW) begin
				if (item.char_code == CHAR_NEWLINE) begin
					cursor_x_q <= '0;
					cursor_y_q <= cursor_y_q + CUR_W'(line_advance_q);
				end else if (!draw_hit) begin
					cursor_x_q <= cursor_x_q + UNMAPPED_ADV;
				end
			end else if (move_s1 && row_s1 == ROW_W'(GLYPH_ROWS - 1)) begin
				cursor_x_q <= cursor_x_q + CUR_W'(widest_nxt) + GLYPH_GAP;
			end else begin
				cursor_x_q <= cursor_x_q;
			end
		end
	end

	// read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && item.action == ACT_DRAW
						&& item.char_code != CHAR_NEWLINE && draw_hit) begin
						state_q <= ST_RUN;
						row_q   <= '0;
					end
				end
				ST_RUN: begin
					if (rd_go) begin
						row_q <= row_q + 1'b1;
						if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// glyph slot and row address walk
	always_ff @(posedge clk) begin
		if (in_acc) begin
			glyph_q <= map.idx;
			addr_q  <= base_addr;
		end else if (rd_go) begin
			addr_q <= addr_q + ADDR_W'(row_stride_q);
		end
	end

	// memory read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_go) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			row_s1  <= row_q;
			addr_s1 <= addr_q;
		end
		if (move_s1) begin
			widest_q <= widest_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q.row_address <= addr_s1;
			out_data_q.row_bits    <= rd_bits;
			out_data_q.span        <= rd_span;
			out_data_q.last_row    <= (row_s1 == ROW_W'(GLYPH_ROWS - 1));
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// checks
	`PGTR_ASSERT_NOW(a_load_only_quiet, load_ok, (state_q == ST_IDLE) && !valid_s1 && !rd_go,
		"glyph load overlaps a glyph read")
	`PGTR_ASSERT_NEXT(a_out_held, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data), "stalled row request changed or dropped")
	`PGTR_ASSERT_NEXT(a_read_fills_stage, rd_go, valid_s1,
		"issued glyph read left the memory stage empty")

endmodule
